// ===== rtl/core/fstpr_pkg.sv =====
// shared types and constants for the first-seen tcp port redirect block
package fstpr_pkg;

    // default sizes and register reset
    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_QUEUE_COUNT   = 64;
    localparam logic [15:0] DEF_TARGET_PORT = 16'd12343;

    // header constants
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] IP_HDR_BYTES   = 16'd20;
    localparam logic [15:0] TCP_HDR_BYTES  = 16'd20;
    localparam logic [15:0] MIN_IP_LEN     = ETH_HDR_BYTES + IP_HDR_BYTES;
    localparam logic [15:0] MIN_TCP_LEN    = ETH_HDR_BYTES + IP_HDR_BYTES + TCP_HDR_BYTES;

    // input request: one parsed frame header
    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [31:0] source_address;
        logic [7:0]  ip_protocol;
        logic [15:0] dest_port;
        logic [7:0]  rx_queue;
    } t_in_req;

    // output request: one verdict
    typedef struct packed {
        logic       verdict;
        logic [5:0] redirect_queue;
        logic       source_known;
    } t_out_req;

    // flags of the lookup probe handed from cell to cell
    typedef struct packed {
        logic hit;
        logic free;
    } t_probe_flags;

    // update command broadcast to all cells
    typedef struct packed {
        logic en;
        logic write;
    } t_cell_cmd;

endpackage

// ===== rtl/core/fstpr_cell.sv =====
// one table entry of the source chain: holds key, valid and age, forwards the probe
module fstpr_cell import fstpr_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int CELL_IDX      = 0,
    localparam int IW = $clog2(TABLE_ENTRIES),
    localparam int LW = IW + 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [31:0]  i_key,
    // probe from the left neighbor
    input  t_probe_flags i_flags,
    input  logic [IW-1:0] i_hit_idx,
    input  logic [IW-1:0] i_hit_age,
    input  logic [IW-1:0] i_free_idx,
    input  logic [IW-1:0] i_best_idx,
    input  logic [IW-1:0] i_best_age,
    // probe to the right neighbor
    output t_probe_flags o_flags,
    output logic [IW-1:0] o_hit_idx,
    output logic [IW-1:0] o_hit_age,
    output logic [IW-1:0] o_free_idx,
    output logic [IW-1:0] o_best_idx,
    output logic [IW-1:0] o_best_age,
    // update command
    input  t_cell_cmd    i_cmd,
    input  logic [IW-1:0] i_cmd_idx,
    input  logic [LW-1:0] i_cmd_limit
);

    logic [31:0]   r_addr;
    logic          r_valid;
    logic [IW-1:0] r_age;

    t_probe_flags  r_flags, n_flags;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [IW-1:0] r_hit_age, n_hit_age;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic [IW-1:0] r_best_idx, n_best_idx;
    logic [IW-1:0] r_best_age, n_best_age;

    logic w_match;
    logic w_take;
    logic w_sel;
    logic w_older;

    // local part of the lookup: first hit, first free slot, oldest entry
    always_comb begin
        w_match = r_valid && (r_addr == i_key);
        w_take  = r_valid && (r_age >= i_best_age);

        n_flags.hit  = i_flags.hit | w_match;
        n_flags.free = i_flags.free | !r_valid;

        n_hit_idx  = i_hit_idx;
        n_hit_age  = i_hit_age;
        if (!i_flags.hit && w_match) begin
            n_hit_idx = IW'(CELL_IDX);
            n_hit_age = r_age;
        end

        n_free_idx = i_free_idx;
        if (!i_flags.free && !r_valid) begin
            n_free_idx = IW'(CELL_IDX);
        end

        n_best_idx = i_best_idx;
        n_best_age = i_best_age;
        if (w_take) begin
            n_best_idx = IW'(CELL_IDX);
            n_best_age = r_age;
        end
    end

    // probe stage register
    always_ff @(posedge i_clk) begin
        r_flags    <= n_flags;
        r_hit_idx  <= n_hit_idx;
        r_hit_age  <= n_hit_age;
        r_free_idx <= n_free_idx;
        r_best_idx <= n_best_idx;
        r_best_age <= n_best_age;
    end

    // entry update: selected entry becomes most recent, younger ones age
    assign w_sel   = i_cmd.en && (i_cmd_idx == IW'(CELL_IDX));
    assign w_older = r_valid && ({1'b0, r_age} < i_cmd_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else if (w_sel) begin
            r_valid <= 1'b1;
            r_age   <= '0;
        end else if (i_cmd.en && w_older) begin
            r_age <= r_age + IW'(1);
        end
    end

    // stored key, no reset
    always_ff @(posedge i_clk) begin
        if (w_sel && i_cmd.write) begin
            r_addr <= i_key;
        end
    end

    assign o_flags    = r_flags;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_age  = r_hit_age;
    assign o_free_idx = r_free_idx;
    assign o_best_idx = r_best_idx;
    assign o_best_age = r_best_age;

endmodule

// ===== rtl/core/first_seen_tcp_port_redirect_top.sv =====
// top level: request handshakes, header checks, control and the chain of table cells
//
// One frame header goes in, one verdict comes out. The source table is a row of
// TABLE_ENTRIES cells; a lookup probe walks the row one cell per cycle. An item is
// accepted, its probe crosses the chain, and then every cell applies the LRU update
// at once and the verdict is loaded into the output register; only then is the next
// item accepted. The input side takes a new request while an earlier verdict still
// waits in the output register; a verdict that cannot be loaded holds the block in
// its update cycle. The target_port register is written through the configuration
// channel, which is always ready, and must only be written while the block is idle.
// No clearing pass is needed after reset.
module first_seen_tcp_port_redirect_top import fstpr_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int QUEUE_COUNT   = DEF_QUEUE_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_req,
    // output requests
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_req    o_out_req
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int LW = IW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD
    } t_state;

    t_state        r_state;
    logic [IW-1:0] r_cnt;
    logic [15:0]   r_target_port;
    logic          r_out_valid;
    t_out_req      r_out_req;

    // captured item
    logic [31:0]   r_key;
    logic          r_qual;
    logic          r_tcp;
    logic          r_fits;
    logic [5:0]    r_queue;

    logic w_in_acc;
    logic w_slot_free;
    logic w_qual;
    logic w_fits;

    // probe chain wires, stage 0 is the empty probe
    t_probe_flags  w_flags    [0:TABLE_ENTRIES];
    logic [IW-1:0] w_hit_idx  [0:TABLE_ENTRIES];
    logic [IW-1:0] w_hit_age  [0:TABLE_ENTRIES];
    logic [IW-1:0] w_free_idx [0:TABLE_ENTRIES];
    logic [IW-1:0] w_best_idx [0:TABLE_ENTRIES];
    logic [IW-1:0] w_best_age [0:TABLE_ENTRIES];

    t_cell_cmd     w_cmd;
    logic [IW-1:0] w_cmd_idx;
    logic [LW-1:0] w_cmd_limit;
    t_out_req      w_result;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // header checks on the incoming request
    assign w_qual = ({1'b0, i_in_req.rx_queue} < 9'(QUEUE_COUNT))
                 && (i_in_req.frame_length >= ETH_HDR_BYTES)
                 && (i_in_req.ether_type == ETHERTYPE_IPV4)
                 && (i_in_req.frame_length >= MIN_IP_LEN);
    assign w_fits = (i_in_req.frame_length >= MIN_TCP_LEN)
                 && (i_in_req.dest_port == r_target_port);

    // update command and verdict from the probe at the end of the chain
    always_comb begin
        w_cmd.en    = 1'b0;
        w_cmd.write = 1'b0;
        w_cmd_idx   = w_hit_idx[TABLE_ENTRIES];
        w_cmd_limit = {1'b0, w_hit_age[TABLE_ENTRIES]};
        w_result    = '0;
        if (r_qual) begin
            if (w_flags[TABLE_ENTRIES].hit) begin
                w_cmd.en              = 1'b1;
                w_result.source_known = 1'b1;
            end else if (r_tcp) begin
                w_cmd.en    = 1'b1;
                w_cmd.write = 1'b1;
                w_cmd_idx   = w_flags[TABLE_ENTRIES].free ? w_free_idx[TABLE_ENTRIES]
                                                          : w_best_idx[TABLE_ENTRIES];
                w_cmd_limit = LW'(TABLE_ENTRIES);
                if (r_fits) begin
                    w_result.verdict        = 1'b1;
                    w_result.redirect_queue = r_queue;
                end
            end
        end
        if (!((r_state == S_UPD) && w_slot_free)) begin
            w_cmd.en = 1'b0;
        end
    end

    // control state, captured item and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_target_port <= DEF_TARGET_PORT;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_target_port <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_key   <= i_in_req.source_address;
                        r_qual  <= w_qual;
                        r_tcp   <= (i_in_req.ip_protocol == PROTO_TCP);
                        r_fits  <= w_fits;
                        r_queue <= i_in_req.rx_queue[5:0];
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + IW'(1);
                    if (r_cnt == IW'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_req   <= w_result;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    // empty probe entering the chain
    assign w_flags[0]    = '0;
    assign w_hit_idx[0]  = '0;
    assign w_hit_age[0]  = '0;
    assign w_free_idx[0] = '0;
    assign w_best_idx[0] = '0;
    assign w_best_age[0] = '0;

    // row of table cells
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        fstpr_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .CELL_IDX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_key),
            .i_flags     (w_flags[g]),
            .i_hit_idx   (w_hit_idx[g]),
            .i_hit_age   (w_hit_age[g]),
            .i_free_idx  (w_free_idx[g]),
            .i_best_idx  (w_best_idx[g]),
            .i_best_age  (w_best_age[g]),
            .o_flags     (w_flags[g+1]),
            .o_hit_idx   (w_hit_idx[g+1]),
            .o_hit_age   (w_hit_age[g+1]),
            .o_free_idx  (w_free_idx[g+1]),
            .o_best_idx  (w_best_idx[g+1]),
            .o_best_age  (w_best_age[g+1]),
            .i_cmd       (w_cmd),
            .i_cmd_idx   (w_cmd_idx),
            .i_cmd_limit (w_cmd_limit)
        );
    end

`ifndef ASSERT_OFF
    // an accepted request always starts a scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_SCAN))
        else $error("accepted request did not start a scan");

    // a new verdict only follows an update cycle
    a_result_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_UPD))
        else $error("verdict raised outside an update cycle");

    // a redirect never goes to a known source
    a_redirect_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_req.verdict && o_out_req.source_known))
        else $error("redirect issued for a known source");

    // the table is only updated when the verdict is loaded
    a_cmd_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.en |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("table update without a loaded verdict");
`endif

endmodule
